[src/assert_macros.svh]
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/seglcd_pkg.sv]
`timescale 1ns / 1ps

package seglcd_pkg;

  localparam int MEMORY_BYTES_DEF  = 20;
  localparam int UPPER_COLUMNS     = 8;
  localparam int LOWER_COLUMNS     = 7;
  localparam int DIGIT_STRIDE_BITS = 2;
  localparam int SEGMENTS          = 7;
  localparam int SYMBOL_COUNT      = 14;
  localparam int NUM_OPS           = SEGMENTS + 1;
  localparam int BYTE_W            = 5;

  localparam logic [3:0] SYMBOL_UNMAPPED = 4'd6;
  localparam logic [7:0] CHAR_PERIOD     = 8'h2E;

  typedef enum logic [2:0] {
    CMD_PUT_CHAR = 3'd0,
    CMD_DP       = 3'd1,
    CMD_SYMBOL   = 3'd2,
    CMD_FILL     = 3'd3,
    CMD_READ     = 3'd4
  } cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] char_code;
    logic [2:0] column;
    logic       row;
    logic [3:0] symbol;
    logic       turn_on;
    logic [7:0] fill_value;
    logic [4:0] byte_address;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_no;
    logic [2:0]        bit_no;
  } seg_pos_t;

  typedef struct packed {
    logic     en;
    seg_pos_t pos;
    logic     value;
  } wr_op_t;

  typedef struct packed {
    wr_op_t [NUM_OPS-1:0] ops;
    logic                 fill_en;
    logic                 rd_en;
    logic                 status;
  } map_t;

  function automatic seg_pos_t upper_base(input logic [2:0] s);
    case (s)
      3'd0:    return '{5'd7,  3'd6};
      3'd1:    return '{5'd2,  3'd6};
      3'd2:    return '{5'd2,  3'd7};
      3'd3:    return '{5'd17, 3'd6};
      3'd4:    return '{5'd12, 3'd6};
      3'd5:    return '{5'd17, 3'd7};
      default: return '{5'd12, 3'd7};
    endcase
  endfunction

  function automatic seg_pos_t lower_base(input logic [2:0] s);
    case (s)
      3'd0:    return '{5'd5,  3'd7};
      3'd1:    return '{5'd0,  3'd7};
      3'd2:    return '{5'd0,  3'd6};
      3'd3:    return '{5'd15, 3'd7};
      3'd4:    return '{5'd10, 3'd7};
      3'd5:    return '{5'd15, 3'd6};
      default: return '{5'd10, 3'd6};
    endcase
  endfunction

  function automatic seg_pos_t upper_dp(input logic [2:0] c);
    case (c)
      3'd0:    return '{5'd7, 3'd7};
      3'd1:    return '{5'd8, 3'd1};
      3'd2:    return '{5'd8, 3'd3};
      3'd3:    return '{5'd8, 3'd5};
      3'd4:    return '{5'd8, 3'd7};
      3'd5:    return '{5'd9, 3'd1};
      default: return '{5'd9, 3'd3};
    endcase
  endfunction

  function automatic seg_pos_t lower_dp(input logic [2:0] c);
    case (c)
      3'd0:    return '{5'd7, 3'd2};
      3'd1:    return '{5'd7, 3'd0};
      3'd2:    return '{5'd6, 3'd6};
      3'd3:    return '{5'd6, 3'd4};
      3'd4:    return '{5'd6, 3'd2};
      default: return '{5'd6, 3'd0};
    endcase
  endfunction

  function automatic seg_pos_t symbol_pos(input logic [3:0] s);
    case (s)
      4'd0:    return '{5'd7,  3'd4};
      4'd1:    return '{5'd7,  3'd5};
      4'd2:    return '{5'd2,  3'd5};
      4'd3:    return '{5'd17, 3'd5};
      4'd4:    return '{5'd2,  3'd4};
      4'd5:    return '{5'd12, 3'd5};
      4'd7:    return '{5'd17, 3'd4};
      4'd8:    return '{5'd10, 3'd1};
      4'd9:    return '{5'd12, 3'd4};
      4'd10:   return '{5'd5,  3'd6};
      4'd11:   return '{5'd9,  3'd5};
      4'd12:   return '{5'd10, 3'd5};
      4'd13:   return '{5'd9,  3'd7};
      default: return '{5'd0,  3'd0};
    endcase
  endfunction

  function automatic logic [SEGMENTS-1:0] glyph(input logic [7:0] c);
    case (c)
      8'h2D:         return 7'h08;
      8'h30:         return 7'h77;
      8'h31:         return 7'h24;
      8'h32:         return 7'h6B;
      8'h33:         return 7'h6D;
      8'h34:         return 7'h3C;
      8'h35:         return 7'h5D;
      8'h36:         return 7'h5F;
      8'h37:         return 7'h64;
      8'h38:         return 7'h7F;
      8'h39:         return 7'h7C;
      8'h41, 8'h61:  return 7'h7E;
      8'h45, 8'h65:  return 7'h5B;
      8'h4C, 8'h6C:  return 7'h13;
      8'h4F, 8'h6F:  return 7'h77;
      8'h50, 8'h70:  return 7'h7A;
      8'h53, 8'h73:  return 7'h5D;
      8'h55, 8'h75:  return 7'h37;
      8'h5F:         return 7'h01;
      default:       return 7'h00;
    endcase
  endfunction

endpackage

[src/segment_lcd_glass_mapper.sv]
`timescale 1ns / 1ps

// Channel   | Handshake               | Payload
// ----------+-------------------------+---------------------------------------------
// request   | in_valid / in_ready     | cmd, char_code, column, row, symbol,
//           |                         | turn_on, fill_value, byte_address
// result    | out_valid / out_ready   | status, read_data
//
// One request per cycle while the result register is not stalled.
// The input register feeds the decode and display memory update; the result register
// is loaded in the same cycle the memory takes its new value.
// Reset clears the display memory to zero and empties both registers.
// A stalled result holds; the input register still takes one more request behind it.

module segment_lcd_glass_mapper #(
  parameter int MEMORY_BYTES = seglcd_pkg::MEMORY_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_cmd,
  input  logic [7:0] in_char_code,
  input  logic [2:0] in_column,
  input  logic       in_row,
  input  logic [3:0] in_symbol,
  input  logic       in_turn_on,
  input  logic [7:0] in_fill_value,
  input  logic [4:0] in_byte_address,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_status,
  output logic [7:0] out_read_data
);

  localparam int AW = $clog2(MEMORY_BYTES);

  logic              s1_valid_r;
  seglcd_pkg::item_t item_r;
  logic              out_valid_r;
  logic              out_status_r;
  logic [7:0]        out_read_data_r;
  logic [7:0]        mem_r   [MEMORY_BYTES];
  logic [7:0]        mem_nxt [MEMORY_BYTES];
  logic [7:0]        read_data_nxt;
  logic              advance;
  seglcd_pkg::map_t  map;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  seglcd_mapper #(
    .MEMORY_BYTES(MEMORY_BYTES)
  ) u_mapper (
    .item(item_r),
    .map (map)
  );

  always_comb begin
    for (int b = 0; b < MEMORY_BYTES; b++) begin
      mem_nxt[b] = map.fill_en ? item_r.fill_value : mem_r[b];
    end
    // later bits win: the digit segments override the cleared point
    for (int s = 0; s < seglcd_pkg::NUM_OPS; s++) begin
      if (map.ops[s].en) begin
        mem_nxt[map.ops[s].pos.byte_no[AW-1:0]][map.ops[s].pos.bit_no] = map.ops[s].value;
      end
    end
    read_data_nxt = map.rd_en ? mem_r[item_r.byte_address[AW-1:0]] : 8'h00;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= '{cmd: in_cmd, char_code: in_char_code, column: in_column, row: in_row,
                  symbol: in_symbol, turn_on: in_turn_on, fill_value: in_fill_value,
                  byte_address: in_byte_address};
    end
    if (advance) begin
      out_status_r    <= map.status;
      out_read_data_r <= read_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int b = 0; b < MEMORY_BYTES; b++) begin
        mem_r[b] <= 8'h00;
      end
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (advance) begin
        for (int b = 0; b < MEMORY_BYTES; b++) begin
          mem_r[b] <= mem_nxt[b];
        end
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_read_data = out_read_data_r;

endmodule

[src/seglcd_mapper.sv]
`timescale 1ns / 1ps

module seglcd_mapper #(
  parameter int MEMORY_BYTES = seglcd_pkg::MEMORY_BYTES_DEF
) (
  input  seglcd_pkg::item_t item,
  output seglcd_pkg::map_t  map
);

  localparam logic [5:0] MEM_LIM = 6'(MEMORY_BYTES);
  localparam logic [2:0] UPPER_LAST = 3'(seglcd_pkg::UPPER_COLUMNS - 1);
  localparam logic [2:0] LOWER_LAST = 3'(seglcd_pkg::LOWER_COLUMNS - 1);

  logic                 col_ok;
  logic                 dp_ok;
  logic [2:0]           digit_idx;
  seglcd_pkg::seg_pos_t dp_pos;
  seglcd_pkg::seg_pos_t base;
  seglcd_pkg::seg_pos_t sym_pos;
  logic [4:0]           bit_pos;
  logic [6:0]           pattern;
  logic                 sym_ok;

  always_comb begin
    col_ok    = item.row ? (item.column <= LOWER_LAST) : (item.column <= UPPER_LAST);
    dp_ok     = item.row ? (item.column < LOWER_LAST) : (item.column < UPPER_LAST);
    digit_idx = item.row ? (LOWER_LAST - item.column) : item.column;
    dp_pos    = item.row ? seglcd_pkg::lower_dp(item.column)
                         : seglcd_pkg::upper_dp(item.column);
    sym_pos   = seglcd_pkg::symbol_pos(item.symbol);
    sym_ok    = (item.symbol < 4'(seglcd_pkg::SYMBOL_COUNT)) &&
                (item.symbol != seglcd_pkg::SYMBOL_UNMAPPED);
    pattern   = seglcd_pkg::glyph(item.char_code);
    base      = '0;
    bit_pos   = '0;

    map.ops     = '0;
    map.fill_en = 1'b0;
    map.rd_en   = 1'b0;
    map.status  = 1'b1;

    // digit segment positions; applied only by put char
    for (int s = 0; s < seglcd_pkg::SEGMENTS; s++) begin
      base    = item.row ? seglcd_pkg::lower_base(3'(s)) : seglcd_pkg::upper_base(3'(s));
      bit_pos = 5'(base.bit_no) + 5'(digit_idx) * 5'(seglcd_pkg::DIGIT_STRIDE_BITS);
      map.ops[s+1].pos.byte_no = base.byte_no + 5'(bit_pos[4:3]);
      map.ops[s+1].pos.bit_no  = bit_pos[2:0];
      map.ops[s+1].value       = pattern[s];
    end

    unique case (seglcd_pkg::cmd_t'(item.cmd))
      seglcd_pkg::CMD_PUT_CHAR: begin
        map.ops[0].pos = dp_pos;
        if (col_ok) begin
          if (item.char_code == seglcd_pkg::CHAR_PERIOD) begin
            map.ops[0].en    = dp_ok;
            map.ops[0].value = 1'b1;
            map.status       = !dp_ok;
          end else begin
            map.ops[0].en    = dp_ok;
            map.ops[0].value = 1'b0;
            for (int s = 1; s < seglcd_pkg::NUM_OPS; s++) begin
              map.ops[s].en = 1'b1;
            end
            map.status = 1'b0;
          end
        end
      end
      seglcd_pkg::CMD_DP: begin
        map.ops[0].pos   = dp_pos;
        map.ops[0].en    = dp_ok;
        map.ops[0].value = item.turn_on;
        map.status       = !dp_ok;
      end
      seglcd_pkg::CMD_SYMBOL: begin
        map.ops[0].pos   = sym_pos;
        map.ops[0].en    = sym_ok;
        map.ops[0].value = item.turn_on;
        map.status       = !sym_ok;
      end
      seglcd_pkg::CMD_FILL: begin
        map.fill_en = 1'b1;
        map.status  = 1'b0;
      end
      seglcd_pkg::CMD_READ: begin
        map.rd_en  = ({1'b0, item.byte_address} < MEM_LIM);
        map.status = !map.rd_en;
      end
      default: begin
        map.status = 1'b1;
      end
    endcase

    // drop bits that fall beyond the memory
    for (int s = 0; s < seglcd_pkg::NUM_OPS; s++) begin
      if ({1'b0, map.ops[s].pos.byte_no} >= MEM_LIM) begin
        map.ops[s].en = 1'b0;
      end
    end
  end

endmodule

[src/seglcd_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module seglcd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_status,
  input logic [7:0] out_read_data
);

  logic       out_stall;
  logic [8:0] out_payload;

  assign out_stall   = out_valid && !out_ready;
  assign out_payload = {out_status, out_read_data};

  `ASSERT_ALWAYS(a_reset_empties_output, !rst_n |=> !out_valid, "result valid after reset")

  `ASSERT_CLK(a_ignored_zero, out_valid && out_status |-> out_read_data == '0, "ignored with data")

  `ASSERT_CLK(a_input_stall_cause, !in_ready |-> out_stall, "input stalled while output free")

  `ASSERT_CLK(a_result_holds, out_stall |=> out_valid && $stable(out_payload), "stalled result changed")

endmodule

bind segment_lcd_glass_mapper seglcd_checker u_seglcd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_status   (out_status),
  .out_read_data(out_read_data)
);
